### rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// shared types and constants for the keyed compacting table
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic match;     // register hit flag
        logic by_index;  // hit on slot number instead of key
        logic sel_ok;    // slot number is a held entry
        logic write;     // load key and handle into the selected slot
        logic shift;     // slots at or above the selected one take their upper neighbor
    } t_cell_ctl;

endpackage

### rtl/kct_if.sv
// ----------------------------------------------------------------------------
// kct_in_if / kct_out_if
// valid/ready channels carrying request and result items
// ----------------------------------------------------------------------------
interface kct_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [kct_pkg::ACTION_W-1:0]  action;
    logic signed [kct_pkg::KEY_W-1:0]     key;
    logic        [kct_pkg::HANDLE_W-1:0]  handle;
    logic signed [kct_pkg::INDEX_W-1:0]   index;

    modport source (output valid, action, key, handle, index, input ready);
    modport sink   (input valid, action, key, handle, index, output ready);
endinterface

interface kct_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic        [kct_pkg::POS_W-1:0]     position;
    logic signed [kct_pkg::KEY_W-1:0]     entry_key;
    logic        [kct_pkg::HANDLE_W-1:0]  entry_handle;
    logic        [kct_pkg::COUNT_W-1:0]   count;

    modport source (output valid, ok, position, entry_key, entry_handle, count, input ready);
    modport sink   (input valid, ok, position, entry_key, entry_handle, count, output ready);
endinterface

### rtl/keyed_compacting_table_unit.sv
// an accepted item passes the match and resolve steps; the resolve step loads its result item
// a new item is taken only back in idle, after the resolve step and, for a successful delete, the shift step
// a result may wait in the output register; the next item is taken meanwhile
// the resolve step holds only while the output register is still full
// reset (i_rst_n low, synchronous) empties the table and drops any pending item
// slot storage is not cleared; slots at or above the count are never read
// ----------------------------------------------------------------------------
// keyed_compacting_table_unit
// insertion-ordered table of key/handle entries kept in a chain of slot cells
// ----------------------------------------------------------------------------
module keyed_compacting_table_unit #(
    parameter int DEPTH = kct_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kct_in_if.sink          i_in,
    kct_out_if.source       o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE,
        S_SHIFT
    } t_state;

    // control and request registers
    t_state                         r_state;
    kct_pkg::t_action               r_act;
    logic [kct_pkg::KEY_W-1:0]      r_key;
    logic [kct_pkg::HANDLE_W-1:0]   r_handle;
    logic [AW-1:0]                  r_sel;
    logic                           r_sel_ok;
    logic [CW-1:0]                  r_count;

    // output register
    logic                           r_out_valid;
    logic                           r_ok;
    logic [kct_pkg::POS_W-1:0]      r_pos;
    logic [kct_pkg::KEY_W-1:0]      r_ekey;
    logic [kct_pkg::HANDLE_W-1:0]   r_ehandle;
    logic [kct_pkg::COUNT_W-1:0]    r_ocnt;

    // cell chain wiring
    logic [kct_pkg::KEY_W-1:0]      w_key    [DEPTH];
    logic [kct_pkg::HANDLE_W-1:0]   w_handle [DEPTH];
    logic [DEPTH-1:0]               w_hit;
    kct_pkg::t_cell_ctl             cell_ctl;
    logic [AW-1:0]                  cell_sel;

    // reduced hit results
    logic                           f_any;
    logic [AW-1:0]                  f_pos;
    logic [kct_pkg::KEY_W-1:0]      f_key;
    logic [kct_pkg::HANDLE_W-1:0]   f_handle;

    // request decode
    logic [31:0]                    idx_w;
    logic [31:0]                    cnt_w;
    logic                           in_fire;
    logic                           out_free;
    logic                           full;
    logic                           ins_ok;
    logic [31:0]                    res_pos_w;
    logic [31:0]                    res_cnt_w;
    logic [CW-1:0]                  next_count;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign full     = r_count == FULL_CNT;
    assign ins_ok   = !f_any && !full;

    // index is signed: bit 7 set means a negative slot, never held
    assign idx_w = 32'(i_in.index[kct_pkg::INDEX_W-2:0]);
    assign cnt_w = 32'(r_count);

    assign i_in.ready = (r_state == S_IDLE);

    // the chain of slot cells, each fed by its upper neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [kct_pkg::KEY_W-1:0]    nxt_key;
        logic [kct_pkg::HANDLE_W-1:0] nxt_handle;

        if (g == DEPTH - 1) begin : g_last
            assign nxt_key    = w_key[g];
            assign nxt_handle = w_handle[g];
        end else begin : g_mid
            assign nxt_key    = w_key[g+1];
            assign nxt_handle = w_handle[g+1];
        end

        kct_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_sel         (cell_sel),
            .i_cnt         (r_count),
            .i_key         (r_key),
            .i_handle      (r_handle),
            .i_next_key    (nxt_key),
            .i_next_handle (nxt_handle),
            .o_key         (w_key[g]),
            .o_handle      (w_handle[g]),
            .o_hit         (w_hit[g])
        );
    end

    // keys are unique, so at most one cell hits: a plain or-reduction picks it
    always_comb begin
        f_any    = 1'b0;
        f_pos    = '0;
        f_key    = '0;
        f_handle = '0;
        for (int i = 0; i < DEPTH; i++) begin
            f_any    = f_any | w_hit[i];
            f_pos    = f_pos | (w_hit[i] ? AW'(i) : '0);
            f_key    = f_key | (w_hit[i] ? w_key[i] : '0);
            f_handle = f_handle | (w_hit[i] ? w_handle[i] : '0);
        end
    end

    // commands to the chain for the current state
    always_comb begin
        cell_ctl          = '0;
        cell_ctl.by_index = (r_act == kct_pkg::ACT_READ);
        cell_ctl.sel_ok   = r_sel_ok;
        cell_sel          = r_sel;
        case (r_state)
            S_MATCH: begin
                cell_ctl.match = 1'b1;
            end
            S_RESOLVE: begin
                // insert lands at the current count, only written when not full and the key is not held
                cell_sel       = r_count[AW-1:0];
                cell_ctl.write = out_free && (r_act == kct_pkg::ACT_INSERT) && ins_ok;
            end
            S_SHIFT: begin
                cell_ctl.shift = 1'b1;
            end
            default: begin
                cell_ctl = '0;
            end
        endcase
    end

    // result fields and count after the step
    always_comb begin
        next_count = r_count;
        res_pos_w  = 32'(f_pos);
        case (r_act)
            kct_pkg::ACT_INSERT: begin
                res_pos_w = ins_ok ? 32'(r_count) : '0;
                if (ins_ok) begin
                    next_count = r_count + CW'(1);
                end
            end
            kct_pkg::ACT_DELETE: begin
                if (f_any) begin
                    next_count = r_count - CW'(1);
                end
            end
            default: begin
                next_count = r_count;
            end
        endcase
        res_cnt_w = 32'(next_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result item loads, otherwise a taken one leaves
            if ((r_state == S_RESOLVE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_act    <= kct_pkg::t_action'(i_in.action);
                        r_key    <= i_in.key;
                        r_handle <= i_in.handle;
                        r_sel    <= idx_w[AW-1:0];
                        r_sel_ok <= !i_in.index[kct_pkg::INDEX_W-1] && (idx_w < cnt_w);
                        r_state  <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_RESOLVE;
                end
                S_RESOLVE: begin
                    if (out_free) begin
                        r_pos       <= res_pos_w[kct_pkg::POS_W-1:0];
                        r_ocnt      <= res_cnt_w[kct_pkg::COUNT_W-1:0];
                        r_count     <= next_count;
                        if (r_act == kct_pkg::ACT_INSERT) begin
                            r_ok      <= ins_ok;
                            r_ekey    <= ins_ok ? r_key : '0;
                            r_ehandle <= ins_ok ? r_handle : '0;
                        end else begin
                            r_ok      <= f_any;
                            r_ekey    <= f_key;
                            r_ehandle <= f_handle;
                        end
                        // a successful delete closes the gap above the removed slot
                        if ((r_act == kct_pkg::ACT_DELETE) && f_any) begin
                            r_sel   <= f_pos;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHIFT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.ok           = r_ok;
    assign o_out.position     = r_pos;
    assign o_out.entry_key    = r_ekey;
    assign o_out.entry_handle = r_ehandle;
    assign o_out.count        = r_ocnt;

endmodule

### rtl/kct_cell.sv
// ----------------------------------------------------------------------------
// kct_cell
// one slot of the table: holds an entry, compares it, shifts from its neighbor
// ----------------------------------------------------------------------------
module kct_cell #(
    parameter int DEPTH = kct_pkg::DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  kct_pkg::t_cell_ctl                 i_ctl,
    input  logic        [AW-1:0]               i_sel,
    input  logic        [CW-1:0]               i_cnt,
    input  logic        [kct_pkg::KEY_W-1:0]   i_key,
    input  logic        [kct_pkg::HANDLE_W-1:0] i_handle,
    input  logic        [kct_pkg::KEY_W-1:0]   i_next_key,
    input  logic        [kct_pkg::HANDLE_W-1:0] i_next_handle,
    output logic        [kct_pkg::KEY_W-1:0]   o_key,
    output logic        [kct_pkg::HANDLE_W-1:0] o_handle,
    output logic                               o_hit
);

    localparam logic [AW-1:0] MY_POS = AW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [kct_pkg::KEY_W-1:0]    r_key;
    logic [kct_pkg::HANDLE_W-1:0] r_handle;
    logic                         r_hit;
    logic                         n_hit;
    logic                         held;

    assign held = MY_CNT < i_cnt;

    always_comb begin
        if (i_ctl.by_index) begin
            n_hit = i_ctl.sel_ok && (i_sel == MY_POS);
        end else begin
            n_hit = held && (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.match) begin
            r_hit <= n_hit;
        end
        if (i_ctl.write && (i_sel == MY_POS)) begin
            r_key    <= i_key;
            r_handle <= i_handle;
        end else if (i_ctl.shift && (MY_POS >= i_sel)) begin
            r_key    <= i_next_key;
            r_handle <= i_next_handle;
        end
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_hit    = r_hit;

endmodule
